// ===== sv/iuv_pkg.sv =====
// Package for the ICMP unreachable validator: header fields, verdict codes and offsets.
package iuv_pkg;

	localparam int MIN_HEADER_WORDS  = 5;
	localparam int ICMP_HEADER_BYTES = 8;
	localparam int QUOTED_BYTES      = 28;
	localparam int SHORT_BYTES       = 20;
	// inner destination sits at bytes 16..19 of the quoted IPv4 header
	localparam int INNER_DEST_OFFSET = ICMP_HEADER_BYTES + 16;
	localparam int INNER_HDR_END     = ICMP_HEADER_BYTES + 20;
	localparam int PAYLOAD_OFFSET    = ICMP_HEADER_BYTES + QUOTED_BYTES;
	localparam logic [7:0] TYPE_UNREACHABLE = 8'd3;

	typedef enum logic [2:0] {
		VERDICT_OK         = 3'd0,
		VERDICT_SHORT      = 3'd1,
		VERDICT_LENGTH     = 3'd2,
		VERDICT_BAD_IHL    = 3'd3,
		VERDICT_NOT_UNREACH = 3'd4,
		VERDICT_DEST       = 3'd5,
		VERDICT_NO_PAYLOAD = 3'd6
	} verdict_t;

	typedef struct packed {
		logic [15:0] total_length;
		logic [3:0]  header_words;
		logic [7:0]  message_type;
		logic [31:0] inner_destination;
		logic        overflowed;
	} hdr_fields_t;

endpackage

// ===== sv/icmp_unreach_validator_unit.sv =====
// Top level of the ICMP destination-unreachable validator.
//
//  channel | direction | tdata / data                                  | side band
//  s_*     | in        | [7:0] rx_byte                                 | tlast last_byte
//  m_*     | out       | [7:0] payload_byte, [10:8] verdict,           | tuser[0] has_payload_byte,
//          |           | [22:11] payload_length, [23] zero             | tlast packet_done
//  cfg_*   | in        | [31:0] expected_inner_destination             | -
//
// One byte per cycle sustained while the output is not stalled; a byte's result passes through
// the input register, then the result register. Results are emitted only for payload bytes
// and the final byte. Reset clears the byte counter, captured fields, register and
// valid flags. An output stall holds the result register and then the input register;
// s_tready drops only when both are full.
module icmp_unreach_validator_unit import iuv_pkg::*; #(
	parameter int BUFFER_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] payload_byte, [10:8] verdict, [22:11] payload_length
	output logic [0:0]  m_tuser,   // [0] has_payload_byte
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int COUNT_W = $clog2(BUFFER_BYTES + 1);

	logic               valid_s1;
	logic [7:0]         rx_byte_s1;
	logic               last_s1;
	logic               advance;
	logic               process;
	logic               has_payload;
	hdr_fields_t        fields_next;
	logic [COUNT_W-1:0] count_next;
	verdict_t           verdict;
	logic [11:0]        plen;
	logic [31:0]        expected_q;

	logic               out_valid_q;
	logic [7:0]         payload_q;
	logic               has_q;
	logic               done_q;
	verdict_t           verdict_q;
	logic [11:0]        plen_q;

	assign advance   = !out_valid_q || m_tready;
	assign process   = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			expected_q <= '0;
		else if (cfg_valid)
			expected_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_byte_s1 <= s_tdata;
			last_s1    <= s_tlast;
		end
	end

	iuv_parser #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.COUNT_W(COUNT_W)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.process(process),
		.rx_byte(rx_byte_s1),
		.last_byte(last_s1),
		.has_payload(has_payload),
		.fields_next(fields_next),
		.count_next(count_next)
	);

	iuv_judge #(
		.COUNT_W(COUNT_W)
	) u_judge (
		.fields(fields_next),
		.byte_count(count_next),
		.expected_inner_destination(expected_q),
		.verdict(verdict),
		.payload_length(plen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= process && (has_payload || last_s1);
	end

	always_ff @(posedge clk) begin
		if (process) begin
			payload_q <= has_payload ? rx_byte_s1 : 8'd0;
			has_q     <= has_payload;
			done_q    <= last_s1;
			verdict_q <= last_s1 ? verdict : VERDICT_OK;
			plen_q    <= last_s1 ? plen : 12'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, plen_q, verdict_q, payload_q};
	assign m_tuser  = has_q;
	assign m_tlast  = done_q;

	a_verdict_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !done_q |-> verdict_q == VERDICT_OK && plen_q == 12'd0)
		else $error("verdict or length set on a non-final result");

	a_length_only_when_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q != VERDICT_OK |-> plen_q == 12'd0)
		else $error("payload length reported with a failing verdict");

	a_empty_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !has_q |-> payload_q == 8'd0 && done_q)
		else $error("result without payload byte must be final and carry zero data");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(rx_byte_s1) && $stable(last_s1))
		else $error("input register changed while stalled");

endmodule

// ===== sv/iuv_parser.sv =====
// Per-byte header capture: byte counter, captured fields and payload byte detection.
module iuv_parser import iuv_pkg::*; #(
	parameter int BUFFER_BYTES = 2048,
	parameter int COUNT_W      = $clog2(BUFFER_BYTES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               process,
	input  logic [7:0]         rx_byte,
	input  logic               last_byte,
	output logic               has_payload,
	output hdr_fields_t        fields_next,
	output logic [COUNT_W-1:0] count_next
);

	hdr_fields_t        fields_q;
	logic [COUNT_W-1:0] count_q;
	logic [5:0]         hb;
	logic [16:0]        off17;
	logic [16:0]        hb17;

	assign off17 = 17'(count_q);
	assign hb17  = 17'(hb);

	always_comb begin
		fields_next = fields_q;
		count_next  = count_q;
		has_payload = 1'b0;
		hb          = {fields_q.header_words, 2'b00};
		if (count_q < COUNT_W'(BUFFER_BYTES)) begin
			// the header length of byte 0 already applies to byte 0
			if (count_q == '0) begin
				fields_next.header_words = rx_byte[3:0];
				hb = {rx_byte[3:0], 2'b00};
			end
			if (count_q == COUNT_W'(2))
				fields_next.total_length[15:8] = rx_byte;
			if (count_q == COUNT_W'(3))
				fields_next.total_length[7:0] = rx_byte;
			if (off17 == hb17)
				fields_next.message_type = rx_byte;
			if (off17 >= hb17 + 17'(INNER_DEST_OFFSET) &&
			    off17 < hb17 + 17'(INNER_DEST_OFFSET + 4))
				fields_next.inner_destination =
					{fields_q.inner_destination[23:0], rx_byte};
			if (off17 >= hb17 + 17'(PAYLOAD_OFFSET))
				has_payload = 1'b1;
			count_next = count_q + COUNT_W'(1);
		end else begin
			fields_next.overflowed = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fields_q <= '0;
			count_q  <= '0;
		end else if (process) begin
			// clear for the next datagram after the final byte
			if (last_byte) begin
				fields_q <= '0;
				count_q  <= '0;
			end else begin
				fields_q <= fields_next;
				count_q  <= count_next;
			end
		end
	end

endmodule

// ===== sv/iuv_judge.sv =====
// Verdict and payload length from the captured fields and the final byte count.
module iuv_judge import iuv_pkg::*; #(
	parameter int COUNT_W = 12
) (
	input  hdr_fields_t        fields,
	input  logic [COUNT_W-1:0] byte_count,
	input  logic [31:0]        expected_inner_destination,
	output verdict_t           verdict,
	output logic [11:0]        payload_length
);

	logic [16:0] n17;
	logic [16:0] hb17;
	logic [16:0] diff;

	assign n17  = 17'(byte_count);
	assign hb17 = 17'({fields.header_words, 2'b00});
	assign diff = n17 - hb17 - 17'(PAYLOAD_OFFSET);

	always_comb begin
		payload_length = 12'd0;
		if (n17 < 17'(SHORT_BYTES))
			verdict = VERDICT_SHORT;
		else if (17'(fields.total_length) != n17 || fields.overflowed)
			verdict = VERDICT_LENGTH;
		else if (fields.header_words < 4'(MIN_HEADER_WORDS) ||
		         hb17 + 17'(ICMP_HEADER_BYTES) > n17)
			verdict = VERDICT_BAD_IHL;
		else if (fields.message_type != TYPE_UNREACHABLE)
			verdict = VERDICT_NOT_UNREACH;
		else if (n17 < hb17 + 17'(INNER_HDR_END))
			verdict = VERDICT_NO_PAYLOAD;
		else if (fields.inner_destination != expected_inner_destination)
			verdict = VERDICT_DEST;
		else if (n17 <= hb17 + 17'(PAYLOAD_OFFSET))
			verdict = VERDICT_NO_PAYLOAD;
		else begin
			verdict        = VERDICT_OK;
			payload_length = diff[11:0];
		end
	end

endmodule

// ===== bench/tb_icmp_unreach_validator_unit.sv =====
// Self-checking testbench for the ICMP unreachable validator: datagram stimulus, verdict prediction.
module tb_icmp_unreach_validator_unit import iuv_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUF_BYTES    = 2048;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_BYTES = 280;

	typedef struct {
		logic [7:0]  payload_byte;
		logic        has_payload;
		logic        packet_done;
		verdict_t    verdict;
		logic [11:0] payload_length;
	} payload_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;   // [7:0] payload_byte, [10:8] verdict, [22:11] payload_length
	logic [0:0]  m_tuser;   // [0] has_payload_byte
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = 32'h0;

	// shadow of the datagram parser
	int          stored_bytes = 0;
	logic [15:0] total_length = 16'h0;
	logic [3:0]  header_words = 4'h0;
	logic [7:0]  message_type = 8'h0;
	logic [31:0] inner_dest = 32'h0;
	logic        spilled = 1'b0;
	logic [31:0] wanted_dest = 32'h0;

	payload_result_t results_due[$];
	payload_result_t seen;
	int          fault_count = 0;
	int          burst_left = 0;
	logic [15:0] stall_cycle = 16'h0;

	icmp_unreach_validator_unit #(
		.BUFFER_BYTES(BUF_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("icmp_unreach_validator_unit regression: fail");
		$finish;
	end

	// receiver: cycle through always-ready, coin-flip, mostly-stalled and periodic phases
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 16'd1;
		case (stall_cycle[8:7])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 1) == 0);
			2'd2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (stall_cycle[1:0] != 2'b11);
		endcase
	end

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fault_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				fault_count++;
				$display("%0t ns: unexpected result, expected none, actual tdata %0h tlast %0b",
					$time, m_tdata, m_tlast);
			end else begin
				seen = results_due.pop_front();
				compare_field("payload_byte", 32'(seen.payload_byte), 32'(m_tdata[7:0]));
				compare_field("verdict", 32'(seen.verdict), 32'(m_tdata[10:8]));
				compare_field("payload_length", 32'(seen.payload_length), 32'(m_tdata[22:11]));
				compare_field("tdata pad", 32'h0, 32'(m_tdata[23]));
				compare_field("has_payload_byte", 32'(seen.has_payload), 32'(m_tuser[0]));
				compare_field("packet_done", 32'(seen.packet_done), 32'(m_tlast));
			end
		end
	end

	// Work out what one accepted byte produces and queue it.
	function automatic void predict_byte(input logic [7:0] b, input logic last);
		payload_result_t r;
		int hb;
		int n;
		logic has;
		has = 1'b0;
		if (stored_bytes < BUF_BYTES) begin
			if (stored_bytes == 0)
				header_words = b[3:0];
			hb = int'(header_words) * 4;
			if (stored_bytes == 2)
				total_length[15:8] = b;
			if (stored_bytes == 3)
				total_length[7:0] = b;
			if (stored_bytes == hb)
				message_type = b;
			if (stored_bytes >= hb + INNER_DEST_OFFSET && stored_bytes < hb + INNER_HDR_END)
				inner_dest = {inner_dest[23:0], b};
			if (stored_bytes >= hb + PAYLOAD_OFFSET)
				has = 1'b1;
			stored_bytes++;
		end else begin
			spilled = 1'b1;
		end
		if (!has && !last)
			return;
		r.payload_byte = has ? b : 8'h00;
		r.has_payload = has;
		r.packet_done = last;
		r.verdict = VERDICT_OK;
		r.payload_length = 12'h0;
		if (last) begin
			n = stored_bytes;
			hb = int'(header_words) * 4;
			if (n < SHORT_BYTES)
				r.verdict = VERDICT_SHORT;
			else if (int'(total_length) != n || spilled)
				r.verdict = VERDICT_LENGTH;
			else if (int'(header_words) < MIN_HEADER_WORDS || hb + ICMP_HEADER_BYTES > n)
				r.verdict = VERDICT_BAD_IHL;
			else if (message_type != TYPE_UNREACHABLE)
				r.verdict = VERDICT_NOT_UNREACH;
			else if (n < hb + INNER_HDR_END)
				r.verdict = VERDICT_NO_PAYLOAD;
			else if (inner_dest != wanted_dest)
				r.verdict = VERDICT_DEST;
			else if (n <= hb + PAYLOAD_OFFSET)
				r.verdict = VERDICT_NO_PAYLOAD;
			else
				r.payload_length = 12'(n - hb - PAYLOAD_OFFSET);
			// clear for the next datagram
			stored_bytes = 0;
			total_length = 16'h0;
			header_words = 4'h0;
			message_type = 8'h0;
			inner_dest = 32'h0;
			spilled = 1'b0;
		end
		results_due.push_back(r);
	endfunction

	// Offer one byte; between bursts hold the request low for a random gap.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 400)
				: $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		predict_byte(b, last);
	endtask

	// Build a datagram of n bytes on the fly: IHL, total length, ICMP type and inner address
	// at their offsets, the rest filled with random, all-zero or all-one bytes.
	task automatic send_datagram(input int n, input int ihl, input int len_field,
			input logic [7:0] mtype, input logic [31:0] dest);
		logic [7:0] b;
		int hb;
		int fill;
		int k;
		hb = ihl * 4;
		fill = $urandom_range(0, 15);
		for (int i = 0; i < n; i++) begin
			b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(0, 255));
			if (i == 0)
				b = {b[7:4], 4'(ihl)};
			if (i == 2)
				b = len_field[15:8];
			if (i == 3)
				b = len_field[7:0];
			if (i == hb && i != 0)
				b = mtype;
			if (i >= hb + INNER_DEST_OFFSET && i < hb + INNER_HDR_END) begin
				k = i - hb - INNER_DEST_OFFSET;
				b = dest[31 - 8 * k -: 8];
			end
			send_byte(b, i == n - 1);
		end
	endtask

	// Drop the request and wait until every result is back.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_inner_destination(input logic [31:0] addr);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_data <= addr;
		do @(posedge clk); while (!cfg_ready);
		wanted_dest = addr;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		// register still holds its reset value of zero
		send_datagram(50, 5, 50, TYPE_UNREACHABLE, 32'h0);
		send_datagram(64, 5, 64, TYPE_UNREACHABLE, 32'h0000_0001);
	endtask

	task automatic test_short_and_length();
		set_inner_destination($urandom);
		send_datagram(1, 5, 1, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(19, 5, 19, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(20, 5, 21, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(64, 5, 16'hFFFF, TYPE_UNREACHABLE, wanted_dest);
	endtask

	task automatic test_header_length();
		send_datagram(20, 5, 20, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(27, 5, 27, TYPE_UNREACHABLE, wanted_dest);
		// short IHL still streams tentative payload bytes
		send_datagram(60, 4, 60, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(40, 0, 40, TYPE_UNREACHABLE, wanted_dest);
	endtask

	task automatic test_type_and_destination();
		set_inner_destination(32'hFFFF_FFFF);
		send_datagram(60, 5, 60, 8'h00, wanted_dest);
		send_datagram(60, 5, 60, 8'hFF, wanted_dest);
		// inner address not yet complete
		send_datagram(28, 5, 28, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(47, 5, 47, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(48, 5, 48, TYPE_UNREACHABLE, 32'h0);
		send_datagram(56, 5, 56, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(57, 5, 57, TYPE_UNREACHABLE, wanted_dest);
	endtask

	task automatic test_payload_bounds();
		set_inner_destination(32'h0);
		send_datagram(97, 15, 97, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(120, 15, 120, TYPE_UNREACHABLE, wanted_dest);
		send_datagram(96, 15, 96, TYPE_UNREACHABLE, wanted_dest);
	endtask

	task automatic test_random_traffic();
		int sent;
		int n;
		int ihl;
		int len_field;
		int flaw;
		logic [7:0] mtype;
		logic [31:0] dest;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: set_inner_destination(32'h0);
					1: set_inner_destination(32'hFFFF_FFFF);
					default: set_inner_destination($urandom);
				endcase
			end
			ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
			n = ihl * 4 + PAYLOAD_OFFSET + $urandom_range(0, 24);
			mtype = TYPE_UNREACHABLE;
			dest = wanted_dest;
			flaw = $urandom_range(0, 19);
			case (flaw)
				0: n = $urandom_range(1, 24);
				1: ihl = $urandom_range(0, 4);
				2: mtype = 8'($urandom_range(0, 255));
				3: dest = $urandom;
				4: n = $urandom_range(ihl * 4 + ICMP_HEADER_BYTES - 2, ihl * 4 + PAYLOAD_OFFSET);
				5: begin
					ihl = $urandom_range(0, 15);
					mtype = 8'($urandom_range(0, 255));
					dest = $urandom;
				end
				default: ;
			endcase
			len_field = n;
			if (flaw == 6)
				len_field = n + (($urandom_range(0, 1) == 0) ? -1 : 1);
			else if (flaw == 5)
				len_field = $urandom_range(0, 65535);
			send_datagram(n, ihl, len_field, mtype, dest);
			sent += n;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_short_and_length();
		test_header_length();
		test_type_and_destination();
		test_payload_bounds();
		test_random_traffic();
		drain_pipeline();
		if (fault_count == 0)
			$display("icmp_unreach_validator_unit regression: pass");
		else
			$display("icmp_unreach_validator_unit regression: fail");
		$finish;
	end

endmodule

// ===== icmp_unreach_validator_unit.f =====
sv/iuv_pkg.sv
sv/iuv_parser.sv
sv/iuv_judge.sv
sv/icmp_unreach_validator_unit.sv
bench/tb_icmp_unreach_validator_unit.sv
